### hdl/uad_pkg.sv
package uad_pkg;

  typedef enum logic [2:0] {
    FN_SAMPLE  = 3'd0,
    FN_BYTE    = 3'd1,
    FN_TICK    = 3'd2,
    FN_UP      = 3'd3,
    FN_DOWN    = 3'd4,
    FN_SWAP    = 3'd5,
    FN_CLEAR   = 3'd6,
    FN_RESTART = 3'd7
  } func_t;

  // receive line codes
  typedef enum logic [1:0] {
    LINE_NONE = 2'd0,
    LINE_A    = 2'd1,
    LINE_B    = 2'd2
  } line_t;

  typedef struct packed {
    logic [2:0] func;
    logic       pin_a_level;
    logic       pin_b_level;
    logic [7:0] rx_data;
  } uad_in_t;

  typedef struct packed {
    logic [1:0]  link_state;
    logic [1:0]  rx_line;
    logic [3:0]  rate_index;
    logic        rate_known;
    logic        manual_mode;
    logic [10:0] top_score;
  } uad_out_t;

  // classified command handed from front to engine
  typedef struct packed {
    func_t      func;
    logic       pin_a;
    logic       pin_b;
    logic [2:0] weight;
  } uad_cmd_t;

endpackage

### hdl/uad_fifo.sv
module uad_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

### hdl/uad_front.sv
module uad_front import uad_pkg::*; (
  input  uad_in_t  item,
  output uad_cmd_t cmd
);

  // character weight: NMEA framing scores high, printable text scores one
  function automatic logic [2:0] byte_weight(input logic [7:0] b);
    logic [2:0] w;
    w = 3'd0;
    case (b) inside
      8'h24:                 w = 3'd5;
      8'h2C, 8'h2A, 8'h0A:   w = 3'd3;
      8'h0D:                 w = 3'd2;
      [8'h20:8'h7E]:         w = 3'd1;
      8'h09, 8'h08:          w = 3'd1;
      default:               w = 3'd0;
    endcase
    return w;
  endfunction

  always_comb begin
    cmd.func   = func_t'(item.func);
    cmd.pin_a  = item.pin_a_level;
    cmd.pin_b  = item.pin_b_level;
    cmd.weight = byte_weight(item.rx_data);
  end

endmodule

### hdl/uad_engine.sv
module uad_engine import uad_pkg::*; #(
  parameter int BUF_LIMIT = 256,
  parameter int NUM_RATES = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] scan_window_ms,
  input  logic [15:0] idle_limit_ms,
  input  logic [23:0] pin_timeout_samples,
  input  logic        cmd_valid,
  input  uad_cmd_t    cmd,
  output logic        cmd_take,
  input  logic        res_full,
  output logic        res_push,
  output uad_out_t    res
);

  localparam int BW = $clog2(BUF_LIMIT + 1);
  localparam logic [BW-1:0] BUF_MAX   = BW'(BUF_LIMIT);
  localparam logic [4:0]    NRATES    = 5'(NUM_RATES);
  localparam logic [3:0]    LAST_RATE = 4'(NUM_RATES - 1);

  typedef enum logic [1:0] {
    LINK_PIN  = 2'd0,
    LINK_SCAN = 2'd1,
    LINK_CONN = 2'd2
  } link_t;

  localparam logic [15:0] FALL_MAX   = 16'hFFFF;
  localparam logic [23:0] SAMPLE_MAX = 24'hFFFFFF;
  localparam logic [15:0] MS_MAX     = 16'hFFFF;
  localparam logic [10:0] SCORE_MAX  = 11'h7FF;
  localparam logic [15:0] PICK_FALLS = 16'd4;
  localparam logic [1:0]  SWEEP_SAT  = 2'd3;
  localparam logic [1:0]  SWEEP_GIVE = 2'd2;

  link_t         mode_r, mode_nxt;
  logic          ovr_r, ovr_nxt;
  logic [1:0]    rx_r, rx_nxt;
  logic [3:0]    rate_r, rate_nxt;
  logic          rv_r, rv_nxt;
  logic [15:0]   fa_r, fa_nxt, fb_r, fb_nxt;
  logic [1:0]    prev_r, prev_nxt;
  logic [23:0]   sc_r, sc_nxt;
  logic [15:0]   el_r, el_nxt;
  logic [BW-1:0] bytes_r, bytes_nxt;
  logic [10:0]   ws_r, ws_nxt;
  logic [10:0]   bs_r, bs_nxt;
  logic [3:0]    bi_r, bi_nxt;
  logic          bv_r, bv_nxt;
  logic [1:0]    sw_r, sw_nxt;

  logic [11:0] sum;
  logic [1:0]  pick;
  logic [3:0]  cur, step_rate;
  logic        do_connect, do_pin_reset, do_base_reset, do_open;

  assign cmd_take = cmd_valid && !res_full;
  assign res_push = cmd_take;

  always_comb begin
    mode_nxt  = mode_r;  ovr_nxt = ovr_r;  rx_nxt = rx_r;
    rate_nxt  = rate_r;  rv_nxt  = rv_r;   fa_nxt = fa_r;  fb_nxt = fb_r;
    prev_nxt  = prev_r;  sc_nxt  = sc_r;   el_nxt = el_r;
    bytes_nxt = bytes_r; ws_nxt  = ws_r;
    bs_nxt    = bs_r;    bi_nxt  = bi_r;   bv_nxt = bv_r;  sw_nxt = sw_r;
    sum = '0; pick = LINE_NONE; cur = '0; step_rate = '0;
    do_connect = 1'b0; do_pin_reset = 1'b0; do_base_reset = 1'b0; do_open = 1'b0;

    case (cmd.func)
      FN_SAMPLE: begin
        if (!ovr_r && mode_r == LINK_PIN) begin
          if (prev_r[0] && !cmd.pin_a && fa_r != FALL_MAX) fa_nxt = fa_r + 1'b1;
          if (prev_r[1] && !cmd.pin_b && fb_r != FALL_MAX) fb_nxt = fb_r + 1'b1;
          prev_nxt = {cmd.pin_b, cmd.pin_a};
          sc_nxt = (sc_r != SAMPLE_MAX) ? sc_r + 1'b1 : sc_r;
          if (fa_nxt >= PICK_FALLS && fa_nxt > fb_nxt) begin
            pick = LINE_A;
          end else if (fb_nxt >= PICK_FALLS && fb_nxt > fa_nxt) begin
            pick = LINE_B;
          end else if (sc_nxt >= pin_timeout_samples) begin
            if (fa_nxt > fb_nxt) pick = LINE_A;
            else if (fb_nxt > fa_nxt) pick = LINE_B;
            else do_pin_reset = 1'b1;
          end
          if (pick != LINE_NONE) begin
            // start the baud scan at rate index 0
            rx_nxt   = pick;
            mode_nxt = LINK_SCAN;
            bs_nxt   = '0;
            bi_nxt   = '0;
            bv_nxt   = 1'b0;
            sw_nxt   = '0;
            rate_nxt = '0;
            rv_nxt   = 1'b1;
            do_open  = 1'b1;
          end
        end
      end
      FN_BYTE: begin
        if (!ovr_r) begin
          if (mode_r == LINK_SCAN) begin
            if (bytes_r < BUF_MAX) begin
              bytes_nxt = bytes_r + 1'b1;
              sum = {1'b0, ws_r} + 12'(cmd.weight);
              ws_nxt = sum[11] ? SCORE_MAX : sum[10:0];
            end
          end else if (mode_r == LINK_CONN) begin
            el_nxt = '0;
          end
        end
      end
      FN_TICK: begin
        if (!ovr_r) begin
          el_nxt = (el_r != MS_MAX) ? el_r + 1'b1 : el_r;
          if (mode_r == LINK_SCAN) begin
            if (el_nxt >= scan_window_ms) begin
              if (ws_r > bs_r) begin
                bs_nxt = ws_r;
                bi_nxt = rate_r;
                bv_nxt = 1'b1;
              end
              if ({1'b0, rate_r} + 5'd1 < NRATES) begin
                rate_nxt = rate_r + 1'b1;
                do_open  = 1'b1;
              end else begin
                sw_nxt = (sw_r < SWEEP_SAT) ? sw_r + 1'b1 : sw_r;
                if (bv_nxt) begin
                  rate_nxt = bi_nxt;
                  rv_nxt   = 1'b1;
                  mode_nxt = LINK_CONN;
                  el_nxt   = '0;
                end else if (sw_nxt >= SWEEP_GIVE) begin
                  sw_nxt       = '0;
                  do_pin_reset = 1'b1;
                end else begin
                  rate_nxt = '0;
                  do_open  = 1'b1;
                end
              end
            end
          end else if (mode_r == LINK_CONN) begin
            if (el_nxt > idle_limit_ms) begin
              rx_nxt       = LINE_NONE;
              rv_nxt       = 1'b0;
              sw_nxt       = '0;
              do_pin_reset = 1'b1;
            end
          end
        end
      end
      FN_UP: begin
        cur = rv_r ? rate_r : '0;
        step_rate = ({1'b0, cur} + 5'd1 < NRATES) ? cur + 1'b1 : '0;
        do_connect = 1'b1;
      end
      FN_DOWN: begin
        cur = rv_r ? rate_r : '0;
        step_rate = (cur != '0 && {1'b0, cur} < NRATES) ? cur - 1'b1 : LAST_RATE;
        do_connect = 1'b1;
      end
      FN_SWAP: begin
        if (rx_r == LINE_A || rx_r == LINE_B) begin
          rx_nxt     = (rx_r == LINE_A) ? LINE_B : LINE_A;
          step_rate  = rv_r ? rate_r : '0;
          do_connect = 1'b1;
        end
      end
      FN_CLEAR: begin
        ovr_nxt       = 1'b0;
        do_base_reset = 1'b1;
      end
      default: begin
        do_base_reset = 1'b1;
      end
    endcase

    if (do_open) begin
      bytes_nxt = '0;
      ws_nxt    = '0;
      el_nxt    = '0;
    end
    if (do_connect) begin
      ovr_nxt  = 1'b1;
      rate_nxt = step_rate;
      rv_nxt   = 1'b1;
      if (rx_nxt != LINE_A && rx_nxt != LINE_B) rx_nxt = LINE_A;
      mode_nxt = LINK_CONN;
      el_nxt   = '0;
    end
    if (do_pin_reset || do_base_reset) begin
      mode_nxt = LINK_PIN;
      fa_nxt   = '0;
      fb_nxt   = '0;
      prev_nxt = 2'b11;
      sc_nxt   = '0;
      el_nxt   = '0;
    end
    if (do_base_reset) begin
      rx_nxt    = LINE_NONE;
      rate_nxt  = '0;
      rv_nxt    = 1'b0;
      bytes_nxt = '0;
      ws_nxt    = '0;
      bs_nxt    = '0;
      bi_nxt    = '0;
      bv_nxt    = 1'b0;
      sw_nxt    = '0;
      // restart under override goes straight to connected
      if (cmd.func == FN_RESTART && ovr_r) mode_nxt = LINK_CONN;
    end
  end

  always_comb begin
    res.link_state  = mode_nxt;
    res.rx_line     = rx_nxt;
    res.rate_index  = rate_nxt;
    res.rate_known  = rv_nxt;
    res.manual_mode = ovr_nxt;
    res.top_score   = bs_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= LINK_PIN;
      ovr_r   <= 1'b0;
      rx_r    <= LINE_NONE;
      rate_r  <= '0;
      rv_r    <= 1'b0;
      fa_r    <= '0;
      fb_r    <= '0;
      prev_r  <= 2'b11;
      sc_r    <= '0;
      el_r    <= '0;
      bytes_r <= '0;
      ws_r    <= '0;
      bs_r    <= '0;
      bi_r    <= '0;
      bv_r    <= 1'b0;
      sw_r    <= '0;
    end else if (cmd_take) begin
      mode_r  <= mode_nxt;
      ovr_r   <= ovr_nxt;
      rx_r    <= rx_nxt;
      rate_r  <= rate_nxt;
      rv_r    <= rv_nxt;
      fa_r    <= fa_nxt;
      fb_r    <= fb_nxt;
      prev_r  <= prev_nxt;
      sc_r    <= sc_nxt;
      el_r    <= el_nxt;
      bytes_r <= bytes_nxt;
      ws_r    <= ws_nxt;
      bs_r    <= bs_nxt;
      bi_r    <= bi_nxt;
      bv_r    <= bv_nxt;
      sw_r    <= sw_nxt;
    end
  end

endmodule

### hdl/uart_pin_and_baud_autodetect_core.sv
// UART pin and baud auto-detect core.
// Input queue (in_data, push/full): one transaction per pin sample, received
// byte, ms tick or manual command; taken at an edge with push high, full low.
// Result queue (out_data, empty/pop): exactly one result per input
// transaction, in order, showing link state after that transaction.
// APB port (psel/penable/pwrite/paddr/pwdata/prdata/pready): three registers
// at 0x0 scan window ms, 0x4 idle limit ms, 0x8 pin timeout samples; write
// only while the core is idle. pready is tied high.
// Accepted transactions are registered in the command queue; engine results
// are registered in the result queue. Throughput: one transaction per cycle
// while the result queue has room; the engine applies one command a cycle.
// Front decodes and weights bytes into a command queue (QUEUE_DEPTH deep);
// engine drains it into a result queue of the same depth. If the receiver
// stalls, the result queue fills, then the command queue, then full rises.
// Reset (rst_n low, synchronous): pin detect, no line, no rate, override off,
// registers back to 200 ms, 5000 ms and 10000 samples; queues emptied.
module uart_pin_and_baud_autodetect_core import uad_pkg::*; #(
  parameter int BUF_LIMIT   = 256,
  parameter int NUM_RATES   = 12,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  uad_in_t     in_data,
  input  logic        push,
  output logic        full,
  // result channel
  output uad_out_t    out_data,
  output logic        empty,
  input  logic        pop,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [1:0] REG_SCAN_WINDOW = 2'd0;
  localparam logic [1:0] REG_IDLE_LIMIT  = 2'd1;
  localparam logic [1:0] REG_PIN_TIMEOUT = 2'd2;

  logic [15:0] scan_window_r;
  logic [15:0] idle_limit_r;
  logic [23:0] pin_timeout_r;
  logic        cfg_wr;
  logic [1:0]  reg_idx;

  uad_cmd_t cmd_in, cmd_out;
  logic     cmd_empty, cmd_take;
  logic     res_full, res_push;
  uad_out_t res;

  // configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_window_r <= 16'd200;
      idle_limit_r  <= 16'd5000;
      pin_timeout_r <= 24'd10000;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_SCAN_WINDOW: scan_window_r <= pwdata[15:0];
        REG_IDLE_LIMIT:  idle_limit_r  <= pwdata[15:0];
        REG_PIN_TIMEOUT: pin_timeout_r <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SCAN_WINDOW: prdata = {16'd0, scan_window_r};
      REG_IDLE_LIMIT:  prdata = {16'd0, idle_limit_r};
      REG_PIN_TIMEOUT: prdata = {8'd0, pin_timeout_r};
      default:         prdata = '0;
    endcase
  end

  // front: decode and classify
  uad_front u_front (
    .item (in_data),
    .cmd  (cmd_in)
  );

  uad_fifo #(
    .WIDTH ($bits(uad_cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (cmd_in),
    .full    (full),
    .pop     (cmd_take),
    .rd_data (cmd_out),
    .empty   (cmd_empty)
  );

  // back: link state engine
  uad_engine #(
    .BUF_LIMIT (BUF_LIMIT),
    .NUM_RATES (NUM_RATES)
  ) u_engine (
    .clk                 (clk),
    .rst_n               (rst_n),
    .scan_window_ms      (scan_window_r),
    .idle_limit_ms       (idle_limit_r),
    .pin_timeout_samples (pin_timeout_r),
    .cmd_valid           (!cmd_empty),
    .cmd                 (cmd_out),
    .cmd_take            (cmd_take),
    .res_full            (res_full),
    .res_push            (res_push),
    .res                 (res)
  );

  uad_fifo #(
    .WIDTH ($bits(uad_out_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res),
    .full    (res_full),
    .pop     (pop),
    .rd_data (out_data),
    .empty   (empty)
  );

endmodule

### dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import uad_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int BUF_LIMIT   = 256;
  localparam int NUM_RATES   = 12;
  localparam int SCORE_CAP   = 2047;
  localparam int NUM_PHASES  = 8;
  // well above the slowest legal run, to leave lots of headroom
  localparam int LIMIT_CYCLES = 500000;
  // margin after the last expected result, covering the path through the core
  localparam int DRAIN_PAD   = 4;

  // APB register map
  localparam logic [3:0] REG_SCAN_WINDOW = 4'h0;
  localparam logic [3:0] REG_IDLE_LIMIT  = 4'h4;
  localparam logic [3:0] REG_PIN_TIMEOUT = 4'h8;

  // directed rows: expectation typed in, or left to the predictor
  localparam bit PREDICT = 1'b0;
  localparam bit TYPED   = 1'b1;

  typedef enum logic [1:0] {
    LINK_PIN  = 2'd0,
    LINK_SCAN = 2'd1,
    LINK_UP   = 2'd2
  } link_t;

  // how the bytes of a scan sweep are shaped
  typedef enum int {
    STYLE_MIXED,
    STYLE_JUNK,
    STYLE_FLOOD
  } sweep_style_t;

  typedef struct {
    uad_in_t  item;
    bit       typed;
    uad_out_t status;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  uad_in_t     in_data = '0;
  logic        push = 1'b0;
  logic        full;
  uad_out_t    out_data;
  logic        empty;
  logic        pop = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  uart_pin_and_baud_autodetect_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .push    (push),
    .full    (full),
    .out_data(out_data),
    .empty   (empty),
    .pop     (pop),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Detector predictor: own copy of the link state and the three registers.
  // ---------------------------------------------------------------------------
  logic [15:0] win_ms_cfg;
  logic [15:0] idle_ms_cfg;
  logic [23:0] pin_timeout_cfg;

  logic [1:0]  det_mode;
  logic        det_override;
  logic [1:0]  det_line;
  logic [3:0]  det_rate;
  logic        det_rate_ok;
  logic [15:0] falls_a;
  logic [15:0] falls_b;
  logic [1:0]  last_levels;      // bit 0 line A, bit 1 line B
  logic [23:0] samples_seen;
  logic [15:0] ms_count;
  logic [8:0]  window_bytes;
  logic [10:0] window_pts;
  logic [10:0] best_pts;
  logic [3:0]  best_rate;
  logic        best_ok;
  logic [1:0]  sweep_count;

  uad_out_t  link_status_q[$];   // expected results, oldest first
  stim_row_t directed_rows[$];
  int        mismatch_count = 0;
  int        cycle_count = 0;

  // stimulus shaping
  bit           steady = 1'b0;   // no gaps or stalls in this phase
  int           pin_favor = 0;   // 0 none, 1 line A toggles, 2 line B toggles
  bit           wave = 1'b1;
  sweep_style_t sweep_style = STYLE_MIXED;
  int           byte_pct = 50;
  int           flood_left = 0;

  // NMEA framing chars score highest, then printables
  function automatic int char_score(logic [7:0] c);
    if (c == "$") return 5;
    if (c == "," || c == "*" || c == 8'h0A) return 3;
    if (c == 8'h0D) return 2;
    if (c >= 8'h20 && c <= 8'h7E) return 1;
    if (c == 8'h09 || c == 8'h08) return 1;
    return 0;
  endfunction

  function automatic void restart_pin_search();
    det_mode     = LINK_PIN;
    falls_a      = '0;
    falls_b      = '0;
    last_levels  = 2'b11;
    samples_seen = '0;
    ms_count     = '0;
  endfunction

  function automatic void begin_rate_window();
    window_bytes = '0;
    window_pts   = '0;
    ms_count     = '0;
  endfunction

  function automatic void begin_sweep(logic [1:0] line);
    det_line    = line;
    det_mode    = LINK_SCAN;
    best_pts    = '0;
    best_rate   = '0;
    best_ok     = 1'b0;
    sweep_count = '0;
    det_rate    = '0;
    det_rate_ok = 1'b1;
    begin_rate_window();
  endfunction

  function automatic void clear_detector();
    restart_pin_search();
    det_line     = LINE_NONE;
    det_rate     = '0;
    det_rate_ok  = 1'b0;
    window_bytes = '0;
    window_pts   = '0;
    best_pts     = '0;
    best_rate    = '0;
    best_ok      = 1'b0;
    sweep_count  = '0;
  endfunction

  function automatic void force_link(logic [3:0] rate);
    det_override = 1'b1;
    det_rate     = rate;
    det_rate_ok  = 1'b1;
    if (det_line != LINE_A && det_line != LINE_B) det_line = LINE_A;
    det_mode     = LINK_UP;
    ms_count     = '0;
  endfunction

  function automatic void count_falls(logic a, logic b);
    logic [1:0] pick;
    pick = LINE_NONE;
    if (last_levels[0] && !a && falls_a != 16'hFFFF) falls_a++;
    if (last_levels[1] && !b && falls_b != 16'hFFFF) falls_b++;
    last_levels = {b, a};
    if (samples_seen != 24'hFFFFFF) samples_seen++;
    if (falls_a >= 4 && falls_a > falls_b) pick = LINE_A;
    else if (falls_b >= 4 && falls_b > falls_a) pick = LINE_B;
    else if (samples_seen >= pin_timeout_cfg) begin
      if (falls_a > falls_b) pick = LINE_A;
      else if (falls_b > falls_a) pick = LINE_B;
      else restart_pin_search();  // tie, zero included: start over
    end
    if (pick != LINE_NONE) begin_sweep(pick);
  endfunction

  function automatic void end_rate_window();
    if (window_pts > best_pts) begin
      best_pts  = window_pts;
      best_rate = det_rate;
      best_ok   = 1'b1;
    end
    if (int'(det_rate) + 1 < NUM_RATES) begin
      det_rate++;
      begin_rate_window();
    end else begin
      if (sweep_count < 3) sweep_count++;
      if (best_ok) begin
        det_rate    = best_rate;
        det_rate_ok = 1'b1;
        det_mode    = LINK_UP;
        ms_count    = '0;
      end else if (sweep_count >= 2) begin
        // second empty sweep: rate and rate_known are left as they are
        sweep_count = '0;
        restart_pin_search();
      end else begin
        det_rate = '0;
        begin_rate_window();
      end
    end
  endfunction

  function automatic uad_out_t predict_link_status(uad_in_t item);
    uad_out_t st;
    int       cur;
    int       pts;
    cur = det_rate_ok ? int'(det_rate) : 0;
    case (func_t'(item.func))
      FN_SAMPLE: begin
        if (!det_override && det_mode == LINK_PIN)
          count_falls(item.pin_a_level, item.pin_b_level);
      end
      FN_BYTE: begin
        if (!det_override) begin
          if (det_mode == LINK_SCAN) begin
            if (window_bytes < BUF_LIMIT) begin
              window_bytes++;
              pts = int'(window_pts) + char_score(item.rx_data);
              window_pts = (pts > SCORE_CAP) ? 11'(SCORE_CAP) : 11'(pts);
            end
          end else if (det_mode == LINK_UP) begin
            ms_count = '0;
          end
        end
      end
      FN_TICK: begin
        if (!det_override) begin
          if (ms_count != 16'hFFFF) ms_count++;
          if (det_mode == LINK_SCAN) begin
            if (ms_count >= win_ms_cfg) end_rate_window();
          end else if (det_mode == LINK_UP) begin
            if (ms_count > idle_ms_cfg) begin
              det_line    = LINE_NONE;
              det_rate_ok = 1'b0;
              sweep_count = '0;
              restart_pin_search();
            end
          end
        end
      end
      FN_UP: force_link((cur + 1 < NUM_RATES) ? 4'(cur + 1) : 4'd0);
      FN_DOWN: force_link((cur >= 1 && cur < NUM_RATES) ? 4'(cur - 1) : 4'(NUM_RATES - 1));
      FN_SWAP: begin
        if (det_line == LINE_A || det_line == LINE_B) begin
          det_line = (det_line == LINE_A) ? LINE_B : LINE_A;
          force_link(det_rate_ok ? det_rate : 4'd0);
        end
      end
      FN_CLEAR: begin
        det_override = 1'b0;
        clear_detector();
      end
      default: begin
        // restart keeps the override; under it the link stays up
        clear_detector();
        if (det_override) det_mode = LINK_UP;
      end
    endcase
    st.link_state  = det_mode;
    st.rx_line     = det_line;
    st.rate_index  = det_rate;
    st.rate_known  = det_rate_ok;
    st.manual_mode = det_override;
    st.top_score   = best_pts;
    return st;
  endfunction

  function automatic uad_out_t link_status(link_t link, line_t line, int rate, bit known,
                                           bit manual);
    uad_out_t st;
    st.link_state  = link;
    st.rx_line     = line;
    st.rate_index  = 4'(rate);
    st.rate_known  = known;
    st.manual_mode = manual;
    st.top_score   = '0;
    return st;
  endfunction

  // ---------------------------------------------------------------------------
  // Random stimulus, steered by the predicted state so that most items build
  // well-formed pin searches, scan sweeps and connected stretches.
  // ---------------------------------------------------------------------------
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] nmea_char();
    logic [7:0] specials[7];
    int         r;
    specials = '{"$", ",", "*", 8'h0A, 8'h0D, 8'h09, 8'h08};
    r = $urandom_range(0, 9);
    if (r < 3) return specials[$urandom_range(0, 6)];
    if (r < 7) return 8'($urandom_range(8'h20, 8'h7E));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (char_score(c) != 0);
    return c;
  endfunction

  function automatic uad_in_t next_stimulus();
    uad_in_t it;
    int      r;
    it.func        = FN_SAMPLE;
    it.pin_a_level = 1'($urandom_range(0, 1));
    it.pin_b_level = 1'($urandom_range(0, 1));
    it.rx_data     = 8'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    if (r < 2) begin
      it.func = 3'($urandom_range(FN_UP, FN_SWAP));
    end else if (r < 3) begin
      it.func = FN_CLEAR;
    end else if (r < 4) begin
      it.func = FN_RESTART;
    end else if (r < 9) begin
      it.func = 3'($urandom_range(0, 7));           // noise
    end else if (det_override) begin
      // mostly feed it events it must ignore; else leave manual mode
      it.func = ($urandom_range(0, 3) == 0) ? FN_CLEAR : 3'($urandom_range(FN_SAMPLE, FN_TICK));
    end else begin
      case (det_mode)
        LINK_PIN: begin
          if (samples_seen == 0 && falls_a == 0 && falls_b == 0)
            pin_favor = $urandom_range(0, 2);
          wave = ~wave;
          it.func        = FN_SAMPLE;
          it.pin_a_level = (pin_favor == 1) ? wave : ($urandom_range(0, 5) != 0);
          it.pin_b_level = (pin_favor == 2) ? wave : ($urandom_range(0, 5) != 0);
        end
        LINK_SCAN: begin
          if (det_rate == 0 && window_bytes == 0 && ms_count == 0) begin
            r = $urandom_range(0, 99);
            sweep_style = (r < 30) ? STYLE_JUNK : (r < 32) ? STYLE_FLOOD : STYLE_MIXED;
            byte_pct    = $urandom_range(20, 85);
            flood_left  = BUF_LIMIT + 8;
          end
          if (sweep_style == STYLE_FLOOD) begin
            // overrun the per-window byte budget with top-scoring chars
            if (flood_left > 0) begin
              flood_left--;
              it.func    = FN_BYTE;
              it.rx_data = "$";
            end else begin
              it.func     = FN_TICK;
              sweep_style = STYLE_MIXED;
            end
          end else if ($urandom_range(0, 99) < byte_pct) begin
            it.func    = FN_BYTE;
            it.rx_data = (sweep_style == STYLE_JUNK) ? junk_char() : nmea_char();
          end else begin
            it.func = FN_TICK;
          end
        end
        default: it.func = ($urandom_range(0, 99) < 65) ? FN_TICK : FN_BYTE;
      endcase
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: one transaction per call, after a random gap.
  // ---------------------------------------------------------------------------
  task automatic send_item(input uad_in_t item, input bit typed, input uad_out_t typed_status);
    int       gap;
    uad_out_t predicted;
    gap = draw_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push    <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (full) @(posedge clk);
    // accepted at this edge
    predicted = predict_link_status(item);
    link_status_q.push_back(typed ? typed_status : predicted);
  endtask

  task automatic add_row(input func_t f, input bit a, input bit b, input logic [7:0] d,
                         input bit typed, input uad_out_t st);
    stim_row_t row;
    row.item.func        = f;
    row.item.pin_a_level = a;
    row.item.pin_b_level = b;
    row.item.rx_data     = d;
    row.typed            = typed;
    row.status           = st;
    directed_rows.push_back(row);
  endtask

  task automatic wait_for_drain();
    push <= 1'b0;
    while (link_status_q.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // APB: setup then access; transfers run back to back, psel drops at the end.
  // ---------------------------------------------------------------------------
  task automatic cfg_access(input bit wr, input logic [3:0] addr, input logic [31:0] data,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
  endtask

  task automatic program_registers(input logic [15:0] scan_ms, input logic [15:0] idle_ms,
                                   input logic [23:0] pin_to);
    logic [3:0]  addrs[3];
    logic [31:0] vals[3];
    logic [31:0] rd;
    addrs = '{REG_SCAN_WINDOW, REG_IDLE_LIMIT, REG_PIN_TIMEOUT};
    vals  = '{{16'd0, scan_ms}, {16'd0, idle_ms}, {8'd0, pin_to}};
    for (int i = 0; i < 3; i++) begin
      cfg_access(1'b1, addrs[i], vals[i], rd);
      cfg_access(1'b0, addrs[i], '0, rd);
      if (rd !== vals[i]) begin
        mismatch_count++;
        $display("%0t: reg 0x%0h readback expected 0x%0h, got 0x%0h",
                 $time, addrs[i], vals[i], rd);
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    win_ms_cfg      = scan_ms;
    idle_ms_cfg     = idle_ms;
    pin_timeout_cfg = pin_to;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random pop stalls, each transaction checked field by field.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [10:0] want,
                             input logic [10:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  initial begin : result_checker
    int       stall_left;
    uad_out_t want;
    stall_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        if (link_status_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with nothing expected, got %p", $time, out_data);
        end else begin
          want = link_status_q.pop_front();
          check_field("link_state", 11'(want.link_state), 11'(out_data.link_state));
          check_field("rx_line", 11'(want.rx_line), 11'(out_data.rx_line));
          check_field("rate_index", 11'(want.rate_index), 11'(out_data.rate_index));
          check_field("rate_known", 11'(want.rate_known), 11'(out_data.rate_known));
          check_field("manual_mode", 11'(want.manual_mode), 11'(out_data.manual_mode));
          check_field("top_score", want.top_score, out_data.top_score);
        end
        stall_left = draw_gap();
      end
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // hard stop if the handshakes hang
  initial begin : watchdog
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed rows at reset defaults, then random phases,
  // each with its own register setting written while the core is idle.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [15:0] scan_ms;
    logic [15:0] idle_ms;
    logic [23:0] pin_to;
    int          count;

    win_ms_cfg      = 16'd200;
    idle_ms_cfg     = 16'd5000;
    pin_timeout_cfg = 24'd10000;
    det_override    = 1'b0;
    clear_detector();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // events out of place in pin detect are dropped
    add_row(FN_TICK, 1'b1, 1'b1, 8'h00, TYPED, '0);
    add_row(FN_BYTE, 1'b1, 1'b1, "$", TYPED, '0);
    add_row(FN_SAMPLE, 1'b1, 1'b1, 8'h00, TYPED, '0);
    // fourth fall on line A beats line B and starts the scan
    add_row(FN_SAMPLE, 1'b0, 1'b1, 8'h00, PREDICT, '0);
    add_row(FN_SAMPLE, 1'b1, 1'b1, 8'h00, PREDICT, '0);
    add_row(FN_SAMPLE, 1'b0, 1'b1, 8'h00, PREDICT, '0);
    add_row(FN_SAMPLE, 1'b1, 1'b1, 8'h00, PREDICT, '0);
    add_row(FN_SAMPLE, 1'b0, 1'b1, 8'h00, PREDICT, '0);
    add_row(FN_SAMPLE, 1'b1, 1'b1, 8'h00, PREDICT, '0);
    add_row(FN_SAMPLE, 1'b0, 1'b1, 8'h00, TYPED, link_status(LINK_SCAN, LINE_A, 0, 1, 0));
    // one of each score class, plus both data extremes
    add_row(FN_BYTE, 1'b1, 1'b1, "$", PREDICT, '0);
    add_row(FN_BYTE, 1'b1, 1'b1, ",", PREDICT, '0);
    add_row(FN_BYTE, 1'b1, 1'b1, 8'h0D, PREDICT, '0);
    add_row(FN_BYTE, 1'b1, 1'b1, "A", PREDICT, '0);
    add_row(FN_BYTE, 1'b1, 1'b1, 8'h00, PREDICT, '0);
    add_row(FN_BYTE, 0, 0, 8'hFF, PREDICT, '0);
    add_row(FN_TICK, 1'b1, 1'b1, 8'h00, PREDICT, '0);
    // manual control: swap, stepping with wrap both ways, clear, restart
    add_row(FN_SWAP, 1'b1, 1'b1, 8'h00, TYPED, link_status(LINK_UP, LINE_B, 0, 1, 1));
    add_row(FN_UP, 1'b1, 1'b1, 8'h00, TYPED, link_status(LINK_UP, LINE_B, 1, 1, 1));
    add_row(FN_DOWN, 1'b1, 1'b1, 8'h00, TYPED, link_status(LINK_UP, LINE_B, 0, 1, 1));
    add_row(FN_DOWN, 1'b1, 1'b1, 8'h00, TYPED, link_status(LINK_UP, LINE_B, 11, 1, 1));
    add_row(FN_UP, 1'b1, 1'b1, 8'h00, TYPED, link_status(LINK_UP, LINE_B, 0, 1, 1));
    add_row(FN_CLEAR, 1'b1, 1'b1, 8'h00, TYPED, '0);
    add_row(FN_DOWN, 1'b1, 1'b1, 8'h00, TYPED, link_status(LINK_UP, LINE_A, 11, 1, 1));
    add_row(FN_RESTART, 1'b1, 1'b1, 8'h00, TYPED, link_status(LINK_UP, LINE_NONE, 0, 0, 1));
    // swap with no line known does nothing
    add_row(FN_SWAP, 1'b1, 1'b1, 8'h00, TYPED, link_status(LINK_UP, LINE_NONE, 0, 0, 1));
    add_row(FN_CLEAR, 1'b1, 1'b1, 8'h00, TYPED, '0);

    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].status);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      wait_for_drain();
      case (phase)
        0: begin            // shortest windows, fastest drop, decide on first sample
          scan_ms = 16'd1;
          idle_ms = 16'd1;
          pin_to  = 24'd1;
        end
        1: begin            // longest: windows never close, idle never drops
          scan_ms = 16'hFFFF;
          idle_ms = 16'hFFFF;
          pin_to  = 24'hFFFFFF;
        end
        default: begin
          scan_ms = 16'($urandom_range(1, 4));
          idle_ms = 16'($urandom_range(1, 25));
          pin_to  = 24'($urandom_range(1, 60));
        end
      endcase
      program_registers(scan_ms, idle_ms, pin_to);
      steady = (phase % 3 == 2);
      count  = (phase == 1) ? 60 : 140;
      for (int n = 0; n < count; n++) send_item(next_stimulus(), PREDICT, '0);
    end

    wait_for_drain();
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
